// File: rtl/core/cdc_pkg.sv
// Package for the calendar day counter: transaction types, calendar constants
// and the leap-year and month-length functions.
// No dependencies.
package cdc_pkg;

   typedef enum logic {
      FUNC_ADVANCE = 1'b0,
      FUNC_LOAD    = 1'b1
   } func_type;

   typedef struct packed {
      func_type           func;
      logic [4:0]         load_day;
      logic [3:0]         load_month;
      logic signed [15:0] load_year;
      logic [23:0]        load_day_number;
   } item_type;

   typedef struct packed {
      logic [4:0]         day;
      logic [3:0]         month;
      logic signed [15:0] year;
      logic [23:0]        day_number;
   } date_type;

   localparam logic [4:0]         RESET_DAY        = 5'd1;
   localparam logic [3:0]         RESET_MONTH      = 4'd1;
   localparam logic signed [15:0] RESET_YEAR       = -16'sd4713;
   localparam logic [23:0]        RESET_DAY_NUMBER = 24'd0;

   localparam logic signed [15:0] YEAR_MAX         = 16'sd32767;
   localparam logic signed [15:0] REFORM_YEAR      = 16'sd1582;
   localparam logic [3:0]         REFORM_MONTH     = 4'd10;
   localparam logic [4:0]         REFORM_LAST_DAY  = 5'd4;
   localparam logic [4:0]         REFORM_NEXT_DAY  = 5'd15;
   localparam logic [3:0]         MONTHS_PER_YEAR  = 4'd12;
   localparam logic [3:0]         FEBRUARY         = 4'd2;
   localparam logic [4:0]         LEAP_FEB_DAYS    = 5'd29;

   // Multiplicative inverse of 25 mod 2^16; y is a multiple of 25 exactly
   // when y * inverse mod 2^16 is at most (2^16 - 1) / 25.
   localparam logic [15:0] INV_25      = 16'h5C29;
   localparam logic [15:0] DIV25_LIMIT = 16'(65535 / 25);

   // Months 0 and 13..15 count as 31 days.
   localparam logic [4:0] MONTH_LEN [16] = '{
      5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
      5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31
   };

   function automatic logic is_leap(logic signed [15:0] year);
      logic [15:0] mag;
      logic [31:0] prod;
      logic        div25;
      logic        leap;
      mag   = 16'(-year);
      prod  = 32'(16'(year)) * 32'(INV_25);
      div25 = (prod[15:0] <= DIV25_LIMIT);
      priority if (year[15]) begin
         leap = (mag[1:0] == 2'b01);
      end else if (year <= REFORM_YEAR) begin
         leap = (year[1:0] == 2'b00);
      end else begin
         leap = ((year[1:0] == 2'b00) && !div25) || ((year[3:0] == 4'b0000) && div25);
      end
      return leap;
   endfunction

   function automatic logic [4:0] days_in(logic [3:0] month, logic signed [15:0] year);
      logic [4:0] len;
      if ((month == FEBRUARY) && is_leap(year)) begin
         len = LEAP_FEB_DAYS;
      end else begin
         len = MONTH_LEN[month];
      end
      return len;
   endfunction

endpackage

// File: rtl/core/calendar_day_counter.sv
// Top level of the calendar day counter: input register, next-date logic and
// result register. Depends on cdc_pkg, cdc_in_reg, cdc_next_date, cdc_out_reg.
//
//   channel  ports                                  direction
//   req      req_valid/req_ready, req_func, req_load_*   in
//   rsp      rsp_valid/rsp_ready, rsp_day .. rsp_overflow out
//
// One transaction per cycle unless rsp stalls; rsp_valid rises once a req moves on
// into the result register. The date update between the registers is combinational.
// Reset: date 1 January 4713 BC, day number 0, both stages empty.
// A stalled rsp holds the result register; req stays open while the input
// register is empty or its transaction can move on in the same cycle.
module calendar_day_counter (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_func,
   input  logic [4:0]         req_load_day,
   input  logic [3:0]         req_load_month,
   input  logic signed [15:0] req_load_year,
   input  logic [23:0]        req_load_day_number,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [4:0]         rsp_day,
   output logic [3:0]         rsp_month,
   output logic signed [15:0] rsp_year,
   output logic [23:0]        rsp_day_number,
   output logic               rsp_overflow
);

   cdc_pkg::item_type req_item;
   cdc_pkg::item_type item;
   logic              item_valid;
   logic              item_move;
   logic              out_free;
   cdc_pkg::date_type cur;
   cdc_pkg::date_type next;
   logic              next_overflow;

   assign req_item.func            = cdc_pkg::func_type'(req_func);
   assign req_item.load_day        = req_load_day;
   assign req_item.load_month      = req_load_month;
   assign req_item.load_year       = req_load_year;
   assign req_item.load_day_number = req_load_day_number;

   cdc_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .out_free   (out_free),
      .item_valid (item_valid),
      .item_move  (item_move),
      .item       (item)
   );

   cdc_next_date u_next_date (
      .cur      (cur),
      .item     (item),
      .next     (next),
      .overflow (next_overflow)
   );

   cdc_out_reg u_out_reg (
      .clock         (clock),
      .reset         (reset),
      .item_move     (item_move),
      .next          (next),
      .next_overflow (next_overflow),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .out_free      (out_free),
      .cur           (cur),
      .overflow      (rsp_overflow)
   );

   assign rsp_day        = cur.day;
   assign rsp_month      = cur.month;
   assign rsp_year       = cur.year;
   assign rsp_day_number = cur.day_number;

`ifndef SYNTH
   a_state_moves_with_item: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(rsp_day_number)) |-> $past(item_move && item_valid))
      else $error("day number changed without a transaction");

   a_overflow_holds_count: assert property (@(posedge clock) disable iff (reset)
      (item_move && next_overflow) |=> $stable(rsp_day_number))
      else $error("refused advance changed the day number");

   a_advance_counts_one: assert property (@(posedge clock) disable iff (reset)
      (item_move && (item.func == cdc_pkg::FUNC_ADVANCE) && !next_overflow)
      |=> (rsp_day_number == 24'($past(rsp_day_number) + 24'd1)))
      else $error("advance did not add one to the day number");
`endif

endmodule

// File: rtl/core/cdc_in_reg.sv
// Input register of the calendar day counter: holds one request transaction.
// Depends on cdc_pkg.
module cdc_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cdc_pkg::item_type req_item,
   input  logic              out_free,
   output logic              item_valid,
   output logic              item_move,
   output cdc_pkg::item_type item
);

   logic              valid_ff;
   logic              valid_in;
   cdc_pkg::item_type item_ff;

   assign item_move = valid_ff && out_free;
   assign req_ready = !valid_ff || out_free;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// File: rtl/core/cdc_next_date.sv
// Next-date logic of the calendar day counter: load, one-day advance with the
// calendar reform gap, year skip and year-limit check.
// Depends on cdc_pkg.
module cdc_next_date (
   input  cdc_pkg::date_type cur,
   input  cdc_pkg::item_type item,
   output cdc_pkg::date_type next,
   output logic              overflow
);

   logic                    gap;
   logic [4:0]              dim;
   logic [5:0]              day_inc;
   logic                    day_carry;
   logic [4:0]              month_inc;
   logic                    year_carry;
   logic signed [15:0]      year_inc;
   logic                    at_limit;
   cdc_pkg::date_type       adv;

   always_comb begin
      gap        = (cur.day == cdc_pkg::REFORM_LAST_DAY) && (cur.month == cdc_pkg::REFORM_MONTH)
                   && (cur.year == cdc_pkg::REFORM_YEAR);
      dim        = cdc_pkg::days_in(cur.month, cur.year);
      day_inc    = {1'b0, cur.day} + 6'd1;
      day_carry  = (day_inc > {1'b0, dim});
      month_inc  = day_carry ? ({1'b0, cur.month} + 5'd1) : {1'b0, cur.month};
      year_carry = (month_inc > {1'b0, cdc_pkg::MONTHS_PER_YEAR});
      year_inc   = (cur.year == -16'sd1) ? 16'sd1 : 16'(cur.year + 16'sd1);
      at_limit   = !gap && year_carry && (cur.year == cdc_pkg::YEAR_MAX);

      adv = cur;
      adv.day_number = 24'(cur.day_number + 24'd1);
      if (gap) begin
         adv.day = cdc_pkg::REFORM_NEXT_DAY;
      end else begin
         adv.day   = day_carry ? 5'd1 : day_inc[4:0];
         adv.month = year_carry ? 4'd1 : month_inc[3:0];
         adv.year  = year_carry ? year_inc : cur.year;
      end

      overflow = 1'b0;
      unique case (item.func)
         cdc_pkg::FUNC_LOAD: begin
            next.day        = item.load_day;
            next.month      = item.load_month;
            next.year       = item.load_year;
            next.day_number = item.load_day_number;
         end
         cdc_pkg::FUNC_ADVANCE: begin
            overflow = at_limit;
            next     = at_limit ? cur : adv;
         end
         default: begin
            next = cur;
         end
      endcase
   end

endmodule

// File: rtl/core/cdc_out_reg.sv
// Result register of the calendar day counter; the held date is also the
// counter state. Depends on cdc_pkg.
module cdc_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_move,
   input  cdc_pkg::date_type next,
   input  logic              next_overflow,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic              out_free,
   output cdc_pkg::date_type cur,
   output logic              overflow
);

   logic              valid_ff;
   logic              valid_in;
   cdc_pkg::date_type date_ff;
   logic              overflow_ff;

   assign out_free = !valid_ff || rsp_ready;
   assign valid_in = item_move || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff           <= 1'b0;
         overflow_ff        <= 1'b0;
         date_ff.day        <= cdc_pkg::RESET_DAY;
         date_ff.month      <= cdc_pkg::RESET_MONTH;
         date_ff.year       <= cdc_pkg::RESET_YEAR;
         date_ff.day_number <= cdc_pkg::RESET_DAY_NUMBER;
      end else begin
         valid_ff <= valid_in;
         if (item_move) begin
            date_ff     <= next;
            overflow_ff <= next_overflow;
         end
      end
   end

   assign rsp_valid = valid_ff;
   assign cur       = date_ff;
   assign overflow  = overflow_ff;

endmodule
